@@ sv/pnfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pnfe_pkg
// Shared types, sizes and codes for the Petri net firing engine.
// ----------------------------------------------------------------------------
package pnfe_pkg;

    localparam int PLACES      = 16;
    localparam int TRANSITIONS = 16;
    localparam int TOKEN_BITS  = 8;

    // Fixed widths of the request and result fields
    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 8;
    localparam int STATUS_W = 2;
    localparam int MASK_W  = 16;

    localparam logic [FUNC_W-1:0] FUNC_ADD_INPUT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_OUTPUT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_TOKENS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIRE       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FUNC = 2'd2;

    typedef logic [TOKEN_BITS-1:0]          token_t;
    typedef logic [PLACES-1:0]              place_mask_t;
    typedef logic [TRANSITIONS-1:0]         trans_mask_t;
    typedef token_t [PLACES-1:0]            marking_t;
    typedef place_mask_t [TRANSITIONS-1:0]  arcs_t;

    localparam token_t TOK_MAX = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] transition_index;
        logic [INDEX_W-1:0] place_index;
        logic [VALUE_W-1:0] token_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MASK_W-1:0]   enabled_mask;
        logic [VALUE_W-1:0]  place_tokens;
    } result_t;

endpackage

@@ sv/petri_net_firing_engine.sv @@
// Flow: a request moves from the request register to the result register while that
// is free or being emptied; a stalled result holds the next request. Throughput: one
// request per cycle while no result stalls; the net update, the enable test over all
// transitions and the result all settle between the request and result registers.
// Reset: clears every token count and every arc mask, and empties both registers.
// ----------------------------------------------------------------------------
// petri_net_firing_engine
// Unit-weight Petri net: arc building, token setting, firing and place queries.
// ----------------------------------------------------------------------------
module petri_net_firing_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  pnfe_pkg::request_t request,
    output logic               result_valid,
    input  logic               result_ready,
    output pnfe_pkg::result_t  result
);
    import pnfe_pkg::*;

    // Request register: holds one accepted request until the core can act on it
    request_t request_reg;
    logic     request_valid_reg, request_valid_next;

    // Result register: holds the finished result until downstream takes it
    result_t  result_reg;
    logic     result_valid_reg, result_valid_next;

    result_t  result_next;
    logic     advance;

    // Advance the held request whenever the result register is free or
    // being emptied this cycle; the net state updates on the same edge,
    // so the following request always sees the state this one leaves.
    assign advance       = request_valid_reg & (~result_valid_reg | result_ready);
    assign request_ready = ~request_valid_reg | advance;

    always_comb
    begin
        request_valid_next = request_valid_reg;
        if (request_ready)
            request_valid_next = request_valid;
        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    pnfe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .request     (request_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_valid_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            request_valid_reg <= request_valid_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // Payload registers: load on the handshake, no reset needed
    always_ff @(posedge clk)
    begin
        if (request_valid & request_ready)
            request_reg <= request;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/pnfe_enable.sv @@
// ----------------------------------------------------------------------------
// pnfe_enable
// Enable test for every transition against a set of non-empty places.
// ----------------------------------------------------------------------------
module pnfe_enable (
    input  pnfe_pkg::arcs_t       input_arcs,
    input  pnfe_pkg::place_mask_t nonzero,
    output pnfe_pkg::trans_mask_t enabled
);
    import pnfe_pkg::*;

    // Enabled when no input place is empty
    always_comb
    begin
        for (int t = 0; t < TRANSITIONS; t++)
        begin
            enabled[t] = ~|(input_arcs[t] & ~nonzero);
        end
    end

endmodule

@@ sv/pnfe_core.sv @@
// ----------------------------------------------------------------------------
// pnfe_core
// Net state (marking and arc masks) with its combinational update and result.
// ----------------------------------------------------------------------------
module pnfe_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  pnfe_pkg::request_t request,
    output pnfe_pkg::result_t  result_next
);
    import pnfe_pkg::*;

    marking_t    marking_reg, marking_next;
    arcs_t       in_arcs_reg, in_arcs_next;
    arcs_t       out_arcs_reg, out_arcs_next;

    place_mask_t nonzero_cur, nonzero_new;
    trans_mask_t enabled_cur, enabled_new;
    place_mask_t place_hot;
    place_mask_t sel_in, sel_out;
    logic        sel_enabled;
    token_t      set_value;
    token_t      after_take;
    logic        take, give;
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   mask;
    logic [VALUE_W-1:0]  tokens;

    always_comb
    begin
        for (int p = 0; p < PLACES; p++)
        begin
            nonzero_cur[p] = |marking_reg[p];
        end
    end

    pnfe_enable u_enable_cur (
        .input_arcs (in_arcs_reg),
        .nonzero    (nonzero_cur),
        .enabled    (enabled_cur)
    );

    // Decode the addressed place and transition
    always_comb
    begin
        place_hot   = '0;
        sel_in      = '0;
        sel_out     = '0;
        sel_enabled = 1'b0;
        for (int p = 0; p < PLACES; p++)
        begin
            place_hot[p] = (int'(request.place_index) == p);
        end
        for (int t = 0; t < TRANSITIONS; t++)
        begin
            if (int'(request.transition_index) == t)
            begin
                sel_in      = in_arcs_reg[t];
                sel_out     = out_arcs_reg[t];
                sel_enabled = enabled_cur[t];
            end
        end
    end

    // Clamp a written count to the top value
    always_comb
    begin
        if (32'(request.token_value) > 32'(TOK_MAX))
            set_value = TOK_MAX;
        else
            set_value = TOKEN_BITS'(request.token_value);
    end

    always_comb
    begin
        marking_next  = marking_reg;
        in_arcs_next  = in_arcs_reg;
        out_arcs_next = out_arcs_reg;
        status        = STATUS_DONE;
        after_take    = '0;
        take          = 1'b0;
        give          = 1'b0;
        case (request.func)
            FUNC_ADD_INPUT:
            begin
                for (int t = 0; t < TRANSITIONS; t++)
                begin
                    if (int'(request.transition_index) == t)
                        in_arcs_next[t] = in_arcs_reg[t] | place_hot;
                end
            end
            FUNC_ADD_OUTPUT:
            begin
                for (int t = 0; t < TRANSITIONS; t++)
                begin
                    if (int'(request.transition_index) == t)
                        out_arcs_next[t] = out_arcs_reg[t] | place_hot;
                end
            end
            FUNC_SET_TOKENS:
            begin
                for (int p = 0; p < PLACES; p++)
                begin
                    if (place_hot[p])
                        marking_next[p] = set_value;
                end
            end
            FUNC_FIRE:
            begin
                if (sel_enabled)
                begin
                    // Take from each input place, then give to each output place
                    for (int p = 0; p < PLACES; p++)
                    begin
                        take            = sel_in[p] & nonzero_cur[p];
                        after_take      = marking_reg[p] - token_t'(take);
                        give            = sel_out[p] & (after_take != TOK_MAX);
                        marking_next[p] = after_take + token_t'(give);
                    end
                end
                else
                begin
                    status = STATUS_REFUSED;
                end
            end
            FUNC_QUERY:
            begin
                status = STATUS_DONE;
            end
            default:
            begin
                status = STATUS_BAD_FUNC;
            end
        endcase
    end

    always_comb
    begin
        for (int p = 0; p < PLACES; p++)
        begin
            nonzero_new[p] = |marking_next[p];
        end
    end

    pnfe_enable u_enable_new (
        .input_arcs (in_arcs_next),
        .nonzero    (nonzero_new),
        .enabled    (enabled_new)
    );

    always_comb
    begin
        mask   = '0;
        tokens = '0;
        for (int t = 0; t < MASK_W; t++)
        begin
            if (t < TRANSITIONS)
                mask[t] = enabled_new[t];
        end
        for (int p = 0; p < PLACES; p++)
        begin
            if (place_hot[p])
                tokens = VALUE_W'(32'(marking_next[p]));
        end
        result_next.status       = status;
        result_next.enabled_mask = mask;
        result_next.place_tokens = tokens;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marking_reg  <= '0;
            in_arcs_reg  <= '0;
            out_arcs_reg <= '0;
        end
        else if (step)
        begin
            marking_reg  <= marking_next;
            in_arcs_reg  <= in_arcs_next;
            out_arcs_reg <= out_arcs_next;
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the Petri net firing engine against an in-bench net predictor.
// Requests go through a directed opening (empty net, duplicate arcs, refused
// and saturating fires, self loops, transitions with no input arcs, unused
// function codes) and then random traffic under three idling mixes. Each
// result is matched field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module tb;

    import pnfe_pkg::*;

    // Function codes left unused by the engine
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_PER_MIX  = 345;
    localparam int REPORT_LIMIT    = 10;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;

    logic     clk           = 1'b0;
    logic     rst_n         = 1'b0;
    logic     request_valid = 1'b0;
    logic     request_ready;
    request_t request       = '0;
    logic     result_valid;
    logic     result_ready  = 1'b0;
    result_t  result;

    petri_net_firing_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Requests waiting to be driven, and the reports the net is due to give
    request_t pending_requests [$];
    result_t  net_reports [$];

    // Shadow of the net: marking and the two arc masks of each transition
    token_t      tally      [PLACES];
    place_mask_t takes_from [TRANSITIONS];
    place_mask_t gives_to   [TRANSITIONS];

    int unsigned sender_idle_pct    = 8;
    int unsigned receiver_stall_pct = 58;
    logic        request_taken      = 1'b0;
    int unsigned mismatch_count     = 0;
    int unsigned requests_accepted  = 0;
    int unsigned fires_taken        = 0;
    int unsigned fires_refused      = 0;
    int unsigned saturated_adds     = 0;
    int unsigned cycle_count        = 0;
    result_t     due;

    initial
    begin
        for (int p = 0; p < PLACES; p++)
            tally[p] = '0;
        for (int t = 0; t < TRANSITIONS; t++)
        begin
            takes_from[t] = '0;
            gives_to[t]   = '0;
        end
    end

    // A transition is enabled when none of its input places is empty
    function automatic trans_mask_t enabled_now();
        place_mask_t marked;
        trans_mask_t en;
        for (int p = 0; p < PLACES; p++)
            marked[p] = (tally[p] != '0);
        for (int t = 0; t < TRANSITIONS; t++)
            en[t] = ((takes_from[t] & ~marked) == '0);
        return en;
    endfunction

    // Apply one request to the shadow net and return the report it earns
    function automatic result_t apply_net_op(request_t r);
        result_t     rep;
        int unsigned t;
        int unsigned p;
        logic        t_ok;
        logic        p_ok;
        trans_mask_t en;
        t = r.transition_index;
        p = r.place_index;
        t_ok = (t < TRANSITIONS);
        p_ok = (p < PLACES);
        rep.status = STATUS_DONE;
        case (r.func)
            FUNC_ADD_INPUT:
                if (t_ok && p_ok)
                    takes_from[t][p] = 1'b1;
            FUNC_ADD_OUTPUT:
                if (t_ok && p_ok)
                    gives_to[t][p] = 1'b1;
            FUNC_SET_TOKENS:
                if (p_ok)
                    tally[p] = (r.token_value > TOK_MAX) ? TOK_MAX : token_t'(r.token_value);
            FUNC_FIRE:
            begin
                en = enabled_now();
                if (t_ok && en[t])
                begin
                    // take from inputs first, then give to outputs
                    for (int q = 0; q < PLACES; q++)
                        if (takes_from[t][q] && tally[q] != '0)
                            tally[q] = tally[q] - 1'b1;
                    for (int q = 0; q < PLACES; q++)
                        if (gives_to[t][q])
                        begin
                            if (tally[q] != TOK_MAX)
                                tally[q] = tally[q] + 1'b1;
                            else
                                saturated_adds++;
                        end
                    fires_taken++;
                end
                else
                begin
                    rep.status = STATUS_REFUSED;
                    fires_refused++;
                end
            end
            FUNC_QUERY:
                ;
            default:
                rep.status = STATUS_BAD_FUNC;
        endcase
        rep.enabled_mask = MASK_W'(enabled_now());
        rep.place_tokens = p_ok ? VALUE_W'(tally[p]) : '0;
        return rep;
    endfunction

    function automatic request_t make_request(logic [FUNC_W-1:0] func, int unsigned t,
                                              int unsigned p, int unsigned v);
        request_t r;
        r.func             = func;
        r.transition_index = INDEX_W'(t);
        r.place_index      = INDEX_W'(p);
        r.token_value      = VALUE_W'(v);
        return r;
    endfunction

    // Mostly fires, sets and queries; arcs are kept rare so the net stays live
    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        int unsigned shade;
        r = make_request(FUNC_QUERY, $urandom_range(15), $urandom_range(15),
                         $urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 7)
            r.func = FUNC_ADD_INPUT;
        else if (pick < 14)
            r.func = FUNC_ADD_OUTPUT;
        else if (pick < 36)
        begin
            r.func = FUNC_SET_TOKENS;
            shade = $urandom_range(9);
            // small counts drain quickly; counts near the top hit saturation
            if (shade < 4)
                r.token_value = VALUE_W'($urandom_range(3));
            else if (shade < 6)
                r.token_value = TOK_MAX - VALUE_W'($urandom_range(1));
        end
        else if (pick < 76)
            r.func = FUNC_FIRE;
        else if (pick < 94)
            r.func = FUNC_QUERY;
        else
            r.func = FUNC_W'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
        return r;
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Hold until every request is driven and every report has come back
    task automatic wait_until_quiet();
        while (pending_requests.size() != 0 || request_valid || net_reports.size() != 0)
            @(posedge clk);
    endtask

    // Driver: change inputs on the falling edge, hold a request until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            request_valid <= 1'b0;
            result_ready  <= 1'b0;
        end
        else
        begin
            if (!request_valid || request_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    request       <= pending_requests.pop_front();
                    request_valid <= 1'b1;
                end
                else
                begin
                    request_valid <= 1'b0;
                end
            end
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        request_taken <= rst_n && request_valid && request_ready;
        if (rst_n)
        begin
            if (request_valid && request_ready)
            begin
                net_reports.insert(net_reports.size(), apply_net_op(request));
                requests_accepted++;
            end
            if (result_valid && result_ready)
            begin
                if (net_reports.size() == 0)
                begin
                    note_mismatch("result with nothing awaited", 0, result);
                end
                else
                begin
                    due = net_reports.pop_front();
                    if (result.status !== due.status)
                        note_mismatch("status", due.status, result.status);
                    if (result.enabled_mask !== due.enabled_mask)
                        note_mismatch("enabled_mask", due.enabled_mask, result.enabled_mask);
                    if (result.place_tokens !== due.place_tokens)
                        note_mismatch("place_tokens", due.place_tokens, result.place_tokens);
                end
            end
        end
    end

    // Watchdog: drop the run if it stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run exceeded %0d cycles with %0d reports outstanding",
                     CYCLE_LIMIT, net_reports.size());
            $display("FAIL petri_net_firing_engine");
            $finish;
        end
    end

    task automatic put(logic [FUNC_W-1:0] func, int unsigned t, int unsigned p,
                       int unsigned v);
        pending_requests.insert(pending_requests.size(), make_request(func, t, p, v));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening, under a slow receiver
        put(FUNC_QUERY, 0, 0, 0);               // empty net: every transition enabled
        put(FUNC_ADD_INPUT, 0, 0, 8'hFF);
        put(FUNC_ADD_INPUT, 0, 1, 0);
        put(FUNC_ADD_INPUT, 0, 0, 0);           // duplicate arc collapses
        put(FUNC_ADD_OUTPUT, 0, 15, 0);
        put(FUNC_FIRE, 0, 0, 0);                // refused: inputs empty
        put(FUNC_SET_TOKENS, 0, 0, 8'hFF);
        put(FUNC_SET_TOKENS, 0, 1, 1);
        put(FUNC_SET_TOKENS, 0, 15, 8'hFE);
        put(FUNC_FIRE, 0, 15, 0);               // output place reaches the top
        put(FUNC_FIRE, 0, 1, 0);                // refused: one input drained
        put(FUNC_SET_TOKENS, 0, 1, 3);
        put(FUNC_FIRE, 0, 15, 0);               // output place saturates
        put(FUNC_ADD_INPUT, 15, 15, 0);
        put(FUNC_ADD_OUTPUT, 15, 0, 0);
        put(FUNC_FIRE, 15, 0, 0);
        put(FUNC_ADD_INPUT, 3, 5, 0);           // place both input and output
        put(FUNC_ADD_OUTPUT, 3, 5, 0);
        put(FUNC_SET_TOKENS, 3, 5, 7);
        put(FUNC_FIRE, 3, 5, 0);
        put(FUNC_SET_TOKENS, 3, 5, 8'hFF);
        put(FUNC_FIRE, 3, 5, 0);
        put(FUNC_ADD_OUTPUT, 7, 2, 0);          // no input arcs: always enabled
        put(FUNC_FIRE, 7, 2, 0);
        put(FUNC_UNUSED_FIRST, 15, 15, 8'hFF);
        put(FUNC_UNUSED_LAST, 9, 4, 8'h5A);
        put(FUNC_SET_TOKENS, 15, 1, 0);
        wait_until_quiet();

        // Random traffic: slow receiver, then slow sender, then no idling.
        // Each mix drains fully before the next begins.
        for (int mix = 0; mix < 3; mix++)
        begin
            sender_idle_pct    = (mix == 1) ? 58 : (mix == 0) ? 8 : 0;
            receiver_stall_pct = (mix == 0) ? 58 : (mix == 1) ? 8 : 0;
            for (int n = 0; n < RANDOM_PER_MIX; n++)
                pending_requests.insert(pending_requests.size(), random_request());
            wait_until_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d requests over three idling mixes: %0d fires taken, %0d refused",
                 requests_accepted, fires_taken, fires_refused);
        $display("%0d token additions held at the top count, %0d mismatches",
                 saturated_adds, mismatch_count);
        if (mismatch_count == 0 && net_reports.size() == 0)
            $display("PASS petri_net_firing_engine");
        else
            $display("FAIL petri_net_firing_engine");
        $finish;
    end

endmodule
